// ===== hdl/dcmf_pkg.sv =====
`default_nettype none

package dcmf_pkg;

  // fifo geometry
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W     = $clog2(2 * FIFO_DEPTH);

  localparam int WORD_W = 32;
  localparam int CTRL_W = 16;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CTRL_W-1:0] ctrl_t;

  // access kinds
  typedef enum logic [1:0] {
    CMD_SEND       = 2'd0,
    CMD_RECV       = 2'd1,
    CMD_CTRL_WRITE = 2'd2,
    CMD_CTRL_READ  = 2'd3
  } cmd_t;

  // control register bit positions
  localparam int B_SEND_EMPTY = 0;
  localparam int B_SEND_FULL  = 1;
  localparam int B_SEND_IRQ   = 2;
  localparam int B_SEND_CLEAR = 3;
  localparam int B_RECV_EMPTY = 8;
  localparam int B_RECV_FULL  = 9;
  localparam int B_RECV_IRQ   = 10;
  localparam int B_ERROR      = 14;
  localparam int B_ENABLE     = 15;

  localparam ctrl_t CTRL_RESET   = 16'h0101;
  localparam ctrl_t WRITE_MASK   = 16'h8404;
  // status masks applied on a successful transfer
  localparam ctrl_t MASK_SEND_SIDE = 16'hBFFC;
  localparam ctrl_t MASK_RECV_SIDE = 16'hBCFF;

  // circular pointer advance
  function automatic ptr_t next_ptr(input ptr_t p);
    ptr_t q;
    q = (int'(p) == FIFO_DEPTH - 1) ? '0 : p + ptr_t'(1);
    return q;
  endfunction

  // flat store address for a processor's fifo slot
  function automatic addr_t store_addr(input logic p, input ptr_t ptr);
    addr_t a;
    a = p ? addr_t'(FIFO_DEPTH + int'(ptr)) : addr_t'(ptr);
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dual_cpu_mailbox_fifo.sv =====
// Two-processor mailbox: each processor owns a send fifo that its partner
// drains, plus a 16-bit control register with empty/full/error/enable status.
// Input channel (in_*): one bus access per transfer. in_tuser carries the
// access kind and the issuing processor, in_tdata the word or control value.
// Result channel (out_*): exactly one result per access, holding the received
// word, the issuer's control register after the access and the interrupt
// pulses for both processors.
// The access is captured in an input register, then the fifo push/pop and
// register update happen in one pass into the result register, which also
// latches the store read, so out_tvalid rises once the access has passed
// through the input and result registers. Throughput is one access per
// cycle while out_tready is high.
// When the receiver stalls, the result register holds and the input register
// still takes one more access; after that in_tready drops until the result
// is taken.
// Reset (rst_n low, synchronous) empties both fifos, sets both control
// registers to 0x0101 and drops both valid flags; store contents are not
// cleared and are only ever read after being written.
`default_nettype none

module dual_cpu_mailbox_fifo
  import dcmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // access input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // data[31:0]
  input  wire logic [2:0]  in_tuser,   // cmd[1:0], proc[2]
  // result output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // read_data[31:0], ctrl_value[47:32],
                                       // irq_send_empty[49:48],
                                       // irq_recv_nonempty[51:50], zero[55:52]
);

  // input register
  logic              in_vld_r;
  cmd_t              cmd_r;
  logic              proc_r;
  logic [WORD_W-1:0] data_r;

  // mailbox state
  ctrl_t ctrl_r [2];
  ptr_t  head_r [2];
  ptr_t  tail_r [2];
  cnt_t  cnt_r  [2];
  ctrl_t ctrl_nxt [2];
  ptr_t  head_nxt [2];
  ptr_t  tail_nxt [2];
  cnt_t  cnt_nxt  [2];

  logic [WORD_W-1:0] store_mem [2*FIFO_DEPTH];

  // result register
  logic              out_vld_r;
  logic [WORD_W-1:0] out_rd_r;
  ctrl_t             out_ctrl_r;
  logic [1:0]        out_ise_r;
  logic [1:0]        out_irn_r;

  // per-access combinational results
  logic       me, other;
  ctrl_t      cl_w, cr_w, wv_w;
  logic       wr_en, rd_en;
  addr_t      wr_addr, rd_addr;
  logic [1:0] ise_w, irn_w;
  logic       advance;
  logic       in_xfer;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || (!out_vld_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  // input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= cmd_t'(in_tuser[1:0]);
      proc_r <= in_tuser[2];
      data_r <= in_tdata;
    end
  end

  // access execution
  always_comb begin
    me      = proc_r;
    other   = ~proc_r;
    cl_w    = ctrl_r[proc_r];
    cr_w    = ctrl_r[~proc_r];
    wv_w    = data_r[CTRL_W-1:0];
    ctrl_nxt = ctrl_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = store_addr(me, tail_r[me]);
    rd_addr = store_addr(other, head_r[other]);
    ise_w   = '0;
    irn_w   = '0;
    unique case (cmd_r)
      CMD_SEND: begin
        if (cl_w[B_ENABLE]) begin
          if (int'(cnt_r[me]) >= FIFO_DEPTH) begin
            ctrl_nxt[me] = cl_w | (ctrl_t'(1) << B_ERROR);
          end else begin
            cl_w = cl_w & MASK_SEND_SIDE;
            cr_w = cr_w & MASK_RECV_SIDE;
            wr_en        = 1'b1;
            tail_nxt[me] = next_ptr(tail_r[me]);
            cnt_nxt[me]  = cnt_r[me] + cnt_t'(1);
            if (int'(cnt_r[me]) == FIFO_DEPTH - 1) begin
              cl_w[B_SEND_FULL] = 1'b1;
              cr_w[B_RECV_FULL] = 1'b1;
            end
            ctrl_nxt[me]    = cl_w;
            ctrl_nxt[other] = cr_w;
            if (cr_w[B_RECV_IRQ]) begin
              irn_w[other] = 1'b1;
            end
          end
        end
      end
      CMD_RECV: begin
        if (cl_w[B_ENABLE]) begin
          if (cnt_r[other] == '0) begin
            ctrl_nxt[me] = cl_w | (ctrl_t'(1) << B_ERROR);
          end else begin
            cl_w = cl_w & MASK_RECV_SIDE;
            cr_w = cr_w & MASK_SEND_SIDE;
            rd_en           = 1'b1;
            head_nxt[other] = next_ptr(head_r[other]);
            cnt_nxt[other]  = cnt_r[other] - cnt_t'(1);
            if (cnt_r[other] == cnt_t'(1)) begin
              cl_w[B_RECV_EMPTY] = 1'b1;
              cr_w[B_SEND_EMPTY] = 1'b1;
              if (cr_w[B_SEND_IRQ]) begin
                ise_w[other] = 1'b1;
              end
            end
            ctrl_nxt[me]    = cl_w;
            ctrl_nxt[other] = cr_w;
          end
        end
      end
      CMD_CTRL_WRITE: begin
        if (wv_w[B_ERROR]) begin
          cl_w[B_ERROR] = 1'b0;
        end
        // flush the issuer's send fifo
        if (wv_w[B_SEND_CLEAR]) begin
          head_nxt[me] = '0;
          tail_nxt[me] = '0;
          cnt_nxt[me]  = '0;
          cl_w[B_SEND_EMPTY] = 1'b1;
          cr_w[B_RECV_EMPTY] = 1'b1;
          cl_w[B_SEND_FULL]  = 1'b0;
          cr_w[B_RECV_FULL]  = 1'b0;
        end
        cl_w = (cl_w & ~WRITE_MASK) | (wv_w & WRITE_MASK);
        if (cl_w[B_SEND_IRQ] && cl_w[B_SEND_EMPTY]) begin
          ise_w[me] = 1'b1;
        end
        if (cl_w[B_RECV_IRQ] && !cl_w[B_RECV_EMPTY]) begin
          irn_w[me] = 1'b1;
        end
        ctrl_nxt[me]    = cl_w;
        ctrl_nxt[other] = cr_w;
      end
      CMD_CTRL_READ: begin
      end
      default: begin
      end
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        ctrl_r[i] <= CTRL_RESET;
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (advance) begin
      ctrl_r <= ctrl_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // fifo store, read data lands in the result register
  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      store_mem[wr_addr] <= data_r;
    end
    if (advance) begin
      out_rd_r <= rd_en ? store_mem[rd_addr] : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ctrl_r <= ctrl_nxt[me];
      out_ise_r  <= ise_w;
      out_irn_r  <= irn_w;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_irn_r, out_ise_r, out_ctrl_r, out_rd_r};

`ifndef SYNTHESIS
  // fill level never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r[0]) <= FIFO_DEPTH && int'(cnt_r[1]) <= FIFO_DEPTH)
    else $error("fifo fill count above depth");

  // send clear is a strobe and never stays in a control register
  a_no_clear_bit: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl_r[0][B_SEND_CLEAR] && !ctrl_r[1][B_SEND_CLEAR])
    else $error("send clear bit stored");

  // empty flags on both sides track fifo 0 fill level
  a_empty0: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r[0][B_SEND_EMPTY] == (cnt_r[0] == '0) &&
    ctrl_r[1][B_RECV_EMPTY] == (cnt_r[0] == '0))
    else $error("fifo 0 empty status out of step");

  // full flags on both sides track fifo 1 fill level
  a_full1: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r[1][B_SEND_FULL] == (int'(cnt_r[1]) == FIFO_DEPTH) &&
    ctrl_r[0][B_RECV_FULL] == (int'(cnt_r[1]) == FIFO_DEPTH))
    else $error("fifo 1 full status out of step");

  // a held result is not overwritten while stalled
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |-> !advance)
    else $error("result overwritten under stall");
`endif

endmodule

`default_nettype wire
